FILE: sv/wpf_pkg.sv
// Shared types, constants and the CRC-8 step for the Wake packet framer.
package wpf_pkg;

  localparam logic [7:0] FEND      = 8'hC0;
  localparam logic [7:0] FESC      = 8'hDB;
  localparam logic [7:0] TFEND     = 8'hDC;
  localparam logic [7:0] TFESC     = 8'hDD;
  localparam logic [7:0] ADDR_FLAG = 8'h80;
  localparam logic [7:0] CRC_XOR   = 8'h18;
  localparam logic [7:0] SEED_RST  = 8'hDE;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic       escape;
    logic       last;
    logic       done;
  } qentry_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] b;
    c = crc_in;
    b = data;
    for (int i = 0; i < 8; i++) begin
      if (b[0] ^ c[0]) begin
        c = ((c ^ CRC_XOR) >> 1) | ADDR_FLAG;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

endpackage

FILE: sv/wpf_if.sv
// Channel interfaces: input items, line bytes and the CRC seed write.
interface wpf_item_if;
  import wpf_pkg::*;
  logic       valid;
  logic       ready;
  logic       action;
  logic       use_address;
  logic [6:0] dest_address;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;
  modport source (output valid, action, use_address, dest_address, command_code,
                  payload_length, payload_byte, input ready);
  modport sink (input valid, action, use_address, dest_address, command_code,
                payload_length, payload_byte, output ready);
endinterface

interface wpf_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_run;
  logic       frame_done;
  modport source (output valid, tx_byte, last_of_run, frame_done, input ready);
  modport sink (input valid, tx_byte, last_of_run, frame_done, output ready);
endinterface

interface wpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] crc_seed;
  modport source (output valid, crc_seed, input ready);
  modport sink (input valid, crc_seed, output ready);
endinterface

FILE: sv/wpf_front.sv
// Front end: accept items, track the packet and push unescaped bytes with CRC.
module wpf_front
  import wpf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  wpf_item_if.sink      item,
  input  logic [7:0]    crc_seed,
  input  logic          q_full,
  output logic          q_push,
  output qentry_t       q_data
);

  typedef enum logic [2:0] {
    S_FEND, S_ADDR, S_CMD, S_LEN, S_DATA, S_CRC
  } step_t;

  logic       busy;
  step_t      step;
  step_t      step_next;
  logic       packet_open;
  logic       packet_open_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [7:0] crc_acc;
  logic [7:0] crc_acc_next;
  logic       use_address;
  logic [6:0] dest_address;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;
  logic       final_step;
  logic       in_fire;

  always_comb begin
    q_data           = '0;
    step_next        = step;
    final_step       = 1'b0;
    packet_open_next = packet_open;
    bytes_left_next  = bytes_left;
    crc_acc_next     = crc_acc;
    unique case (step)
      S_FEND: begin
        q_data.value = FEND;
        crc_acc_next = crc_step(crc_seed, FEND);
        step_next    = use_address ? S_ADDR : S_CMD;
      end
      S_ADDR: begin
        q_data.value  = {1'b1, dest_address};
        q_data.escape = 1'b1;
        crc_acc_next  = crc_step(crc_acc, {1'b0, dest_address});
        step_next     = S_CMD;
      end
      S_CMD: begin
        q_data.value  = command_code;
        q_data.escape = 1'b1;
        crc_acc_next  = crc_step(crc_acc, command_code);
        step_next     = S_LEN;
      end
      S_LEN: begin
        q_data.value     = payload_length;
        q_data.escape    = 1'b1;
        crc_acc_next     = crc_step(crc_acc, payload_length);
        packet_open_next = 1'b1;
        bytes_left_next  = payload_length;
        step_next        = S_CRC;
        final_step       = (payload_length != 8'd0);
        q_data.last      = final_step;
      end
      S_DATA: begin
        q_data.value    = payload_byte;
        q_data.escape   = 1'b1;
        crc_acc_next    = crc_step(crc_acc, payload_byte);
        bytes_left_next = bytes_left - 8'd1;
        step_next       = S_CRC;
        final_step      = (bytes_left_next != 8'd0);
        q_data.last     = final_step;
      end
      S_CRC: begin
        q_data.value     = crc_acc;
        q_data.escape    = 1'b1;
        q_data.last      = 1'b1;
        q_data.done      = 1'b1;
        packet_open_next = 1'b0;
        bytes_left_next  = 8'd0;
        final_step       = 1'b1;
      end
      default: begin
        q_data = '0;
      end
    endcase
    if (!q_push) begin
      packet_open_next = packet_open;
      bytes_left_next  = bytes_left;
      crc_acc_next     = crc_acc;
    end
  end

  assign q_push     = busy && !q_full;
  assign item.ready = !busy || (q_push && final_step);
  assign in_fire    = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      step        <= S_FEND;
      packet_open <= 1'b0;
      bytes_left  <= 8'd0;
      crc_acc     <= 8'd0;
    end else begin
      packet_open <= packet_open_next;
      bytes_left  <= bytes_left_next;
      crc_acc     <= crc_acc_next;
      if (in_fire) begin
        if (item.action == ACT_BEGIN) begin
          busy           <= 1'b1;
          step           <= S_FEND;
          use_address    <= item.use_address;
          dest_address   <= item.dest_address;
          command_code   <= item.command_code;
          payload_length <= item.payload_length;
        end else begin
          busy         <= packet_open_next;
          step         <= S_DATA;
          payload_byte <= item.payload_byte;
        end
      end else if (q_push) begin
        busy <= !final_step;
        step <= step_next;
      end
    end
  end

endmodule

FILE: sv/wpf_queue.sv
// Short byte queue between the front and back ends.
module wpf_queue
  import wpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t wr_data,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output qentry_t rd_data
);

  qentry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/wpf_back.sv
// Back end: escape queued bytes and hold them in the output register.
module wpf_back
  import wpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  qentry_t    q_data,
  output logic       q_pop,
  wpf_line_if.source line
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_done;
  logic       pending;
  logic [7:0] pend_byte;
  logic       pend_last;
  logic       pend_done;
  logic       load;
  logic       needs_esc;

  assign load      = !out_valid || line.ready;
  assign q_pop     = load && !pending && q_valid;
  assign needs_esc = q_data.escape && (q_data.value == FEND || q_data.value == FESC);

  assign line.valid       = out_valid;
  assign line.tx_byte     = out_byte;
  assign line.last_of_run = out_last;
  assign line.frame_done  = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        out_byte  <= pend_byte;
        out_last  <= pend_last;
        out_done  <= pend_done;
        pending   <= 1'b0;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        if (needs_esc) begin
          out_byte  <= FESC;
          out_last  <= 1'b0;
          out_done  <= 1'b0;
          pending   <= 1'b1;
          pend_byte <= (q_data.value == FEND) ? TFEND : TFESC;
          pend_last <= q_data.last;
          pend_done <= q_data.done;
        end else begin
          out_byte <= q_data.value;
          out_last <= q_data.last;
          out_done <= q_data.done;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/wake_packet_framer_top.sv
// Top level of the Wake packet framer: seed register, front end, queue, back end.
//
// Channels: item (sink) takes begin and data items, line (source) gives one
// line byte per beat with last_of_run and frame_done, cfg (sink) writes the
// CRC seed and is always ready.
// A begin item yields the frame-end byte, optional flagged address, command,
// length and, for zero length, the CRC; a data item yields its byte and, on
// the last one, the CRC. All bytes after the frame end are escaped.
// Throughput: the front end pushes one unescaped byte per cycle while the
// queue is not full, and takes the next item in the cycle of its last push;
// the back end gives one line byte per cycle while line is ready, and an
// escaped byte goes out as two line bytes, FESC and then its substitute.
// Reset clears the packet state, the queue and the output register; the seed
// returns to 0xDE. When line is stalled the output register and the
// four-entry queue fill, then item ready drops until space frees.
module wake_packet_framer_top
  import wpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  wpf_item_if.sink   item,
  wpf_line_if.source line,
  wpf_cfg_if.sink    cfg
);

  logic [7:0] crc_seed;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  qentry_t    q_wr;
  qentry_t    q_rd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_seed <= SEED_RST;
    end else if (cfg.valid) begin
      crc_seed <= cfg.crc_seed;
    end
  end

  wpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .crc_seed (crc_seed),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  wpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_rd)
  );

  wpf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .line    (line)
  );

endmodule

FILE: verif/wpf_line_checker.sv
// Checker for the Wake packet framer: predicts line bytes from item beats and compares them.
module wpf_line_checker
  import wpf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  wpf_item_if    item,
  wpf_line_if    line,
  wpf_cfg_if     cfg,
  output int     errors,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic       frame_done;
  } line_beat_t;

  line_beat_t expected_bytes[$];
  line_beat_t run_bytes[$];

  logic [7:0] seed_q;
  logic [7:0] frame_crc;
  logic [7:0] data_left;
  logic       frame_open;

  function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY_REFL;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  task automatic put_line(input logic [7:0] v, input logic esc, input logic done);
    if (esc && (v == FEND || v == FESC)) begin
      run_bytes.push_back('{FESC, 1'b0, 1'b0});
      run_bytes.push_back('{(v == FEND) ? TFEND : TFESC, 1'b0, done});
    end else begin
      run_bytes.push_back('{v, 1'b0, done});
    end
  endtask

  task automatic close_frame();
    put_line(frame_crc, 1'b1, 1'b1);
    frame_open = 1'b0;
    data_left  = 8'd0;
  endtask

  task automatic predict_item();
    line_beat_t tail;
    run_bytes.delete();
    if (item.action == ACT_BEGIN) begin
      frame_crc = crc8_next(seed_q, FEND);
      put_line(FEND, 1'b0, 1'b0);
      if (item.use_address) begin
        frame_crc = crc8_next(frame_crc, {1'b0, item.dest_address});
        put_line({1'b0, item.dest_address} | ADDR_FLAG, 1'b1, 1'b0);
      end
      frame_crc = crc8_next(frame_crc, item.command_code);
      put_line(item.command_code, 1'b1, 1'b0);
      frame_crc = crc8_next(frame_crc, item.payload_length);
      put_line(item.payload_length, 1'b1, 1'b0);
      frame_open = 1'b1;
      data_left  = item.payload_length;
      if (data_left == 8'd0) begin
        close_frame();
      end
    end else if (frame_open) begin
      frame_crc = crc8_next(frame_crc, item.payload_byte);
      put_line(item.payload_byte, 1'b1, 1'b0);
      data_left = data_left - 8'd1;
      if (data_left == 8'd0) begin
        close_frame();
      end
    end
    if (run_bytes.size() > 0) begin
      tail = run_bytes[run_bytes.size() - 1];
      tail.last_of_run = 1'b1;
      run_bytes[run_bytes.size() - 1] = tail;
    end
    foreach (run_bytes[k]) begin
      expected_bytes.push_back(run_bytes[k]);
    end
  endtask

  task automatic check_line();
    line_beat_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected line beat: tx_byte %h", line.tx_byte);
      errors++;
    end else begin
      want = expected_bytes.pop_front();
      if (line.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %h, actual %h", want.tx_byte, line.tx_byte);
        errors++;
      end
      if (line.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, line.last_of_run);
        errors++;
      end
      if (line.frame_done !== want.frame_done) begin
        $error("frame_done: expected %b, actual %b", want.frame_done, line.frame_done);
        errors++;
      end
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_bytes.delete();
      seed_q     = SEED_RST;
      frame_crc  = 8'd0;
      data_left  = 8'd0;
      frame_open = 1'b0;
    end else begin
      if (line.valid && line.ready) begin
        check_line();
      end
      if (cfg.valid && cfg.ready) begin
        seed_q = cfg.crc_seed;
      end
      if (item.valid && item.ready) begin
        predict_item();
      end
    end
    pending = expected_bytes.size();
  end

endmodule

FILE: verif/tb_wake_packet_framer_top.sv
// Testbench top for the Wake packet framer: clock, reset, stimulus, back-pressure and verdict.
module tb_wake_packet_framer_top;
  import wpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_beats;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   items_sent;
  logic pkt_open;
  logic [7:0] seed_now;

  wpf_item_if item_ch();
  wpf_line_if line_ch();
  wpf_cfg_if  cfg_ch();

  wake_packet_framer_top dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .line (line_ch),
    .cfg  (cfg_ch)
  );

  wpf_line_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .line    (line_ch),
    .cfg     (cfg_ch),
    .errors  (fail_count),
    .pending (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    line_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input logic act, input logic use_addr, input logic [6:0] addr,
                           input logic [7:0] cmd, input logic [7:0] len,
                           input logic [7:0] pbyte);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.action         <= act;
    item_ch.use_address    <= use_addr;
    item_ch.dest_address   <= addr;
    item_ch.command_code   <= cmd;
    item_ch.payload_length <= len;
    item_ch.payload_byte   <= pbyte;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic send_begin(input logic use_addr, input logic [6:0] addr,
                            input logic [7:0] cmd, input logic [7:0] len);
    send_item(ACT_BEGIN, use_addr, addr, cmd, len, 8'($urandom));
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(ACT_DATA, 1'($urandom), 7'($urandom), 8'($urandom), 8'($urandom), b);
  endtask

  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_seed(input logic [7:0] v);
    @(negedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.crc_seed <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    seed_now = v;
  endtask

  function automatic logic [7:0] line_value();
    case ($urandom_range(7))
      0:       return FEND;
      1:       return FESC;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_packet();
    logic [7:0] len;
    int         n_data;
    if (!pkt_open && $urandom_range(9) == 0) begin
      send_data(line_value());
    end
    if ($urandom_range(99) < 85) begin
      len = 8'($urandom_range(5));
    end else begin
      len = 8'($urandom);
    end
    send_begin(1'($urandom), 7'($urandom), line_value(), len);
    items_sent++;
    n_data = int'(len);
    if (len > 6 || $urandom_range(9) == 0) begin
      n_data = $urandom_range((len > 6) ? 6 : len);
    end
    for (int i = 0; i < n_data; i++) begin
      send_data(line_value());
      items_sent++;
    end
    pkt_open = (n_data != len);
  endtask

  initial begin
    #1_000_000;
    $display("wake_packet_framer_top verification failed");
    $finish;
  end

  initial begin
    logic [7:0] hdr_crc;
    logic [7:0] hit_fend;
    logic [7:0] hit_fesc;
    logic [7:0] phase_seed [4];

    rst                    = 1'b1;
    src_idle_pct           = 0;
    sink_stall_pct         = 0;
    items_sent             = 0;
    pkt_open               = 1'b0;
    seed_now               = SEED_RST;
    item_ch.valid          = 1'b0;
    item_ch.action         = ACT_BEGIN;
    item_ch.use_address    = 1'b0;
    item_ch.dest_address   = 7'd0;
    item_ch.command_code   = 8'd0;
    item_ch.payload_length = 8'd0;
    item_ch.payload_byte   = 8'd0;
    line_ch.ready          = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.crc_seed        = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pick data bytes that drive the closing CRC onto both reserved values
    hdr_crc = crc_step(crc_step(crc_step(seed_now, FEND), 8'h33), 8'h01);
    hit_fend = 8'd0;
    hit_fesc = 8'd0;
    for (int b = 0; b < 256; b++) begin
      if (crc_step(hdr_crc, 8'(b)) == FEND) hit_fend = 8'(b);
      if (crc_step(hdr_crc, 8'(b)) == FESC) hit_fesc = 8'(b);
    end

    send_data(FEND);
    send_begin(1'b0, 7'h00, 8'h00, 8'h00);
    send_begin(1'b1, 7'h40, FEND, 8'h00);
    send_begin(1'b1, 7'h5B, FESC, 8'h03);
    send_data(FEND);
    send_data(FESC);
    send_data(8'hFF);
    send_begin(1'b1, 7'h7F, 8'hFF, FEND);
    send_data(8'h00);
    send_data(8'h7F);
    send_item(ACT_BEGIN, 1'b1, 7'h00, 8'h12, FESC, 8'hFF);
    send_begin(1'b0, 7'h7F, 8'h33, 8'h01);
    send_data(hit_fend);
    send_begin(1'b0, 7'h2A, 8'h33, 8'h01);
    send_data(hit_fesc);
    send_data(8'hA5);
    send_begin(1'b1, 7'h00, 8'h80, 8'hFF);
    send_data(8'h80);
    send_begin(1'b1, 7'h55, 8'hAA, 8'h00);
    settle();

    phase_seed[0] = 8'h00;
    phase_seed[1] = 8'hFF;
    phase_seed[2] = 8'($urandom);
    phase_seed[3] = SEED_RST;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
      set_seed(phase_seed[ph]);
      pkt_open   = 1'b0;
      items_sent = 0;
      while (items_sent < 48) begin
        random_packet();
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("wake_packet_framer_top verification clean");
    end else begin
      $display("wake_packet_framer_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/wpf_pkg.sv
sv/wpf_if.sv
sv/wpf_front.sv
sv/wpf_queue.sv
sv/wpf_back.sv
sv/wake_packet_framer_top.sv
verif/wpf_line_checker.sv
verif/tb_wake_packet_framer_top.sv
